// ===== hw/rtl/smc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, codes and decode helpers for the stack machine core.
// ----------------------------------------------------------------------------
package smc_pkg;

  // host actions
  localparam logic [2:0] ACT_MEM_WR = 3'd0;
  localparam logic [2:0] ACT_MEM_RD = 3'd1;
  localparam logic [2:0] ACT_DEV_WR = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_STEP   = 3'd4;

  // result status
  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_BRK  = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;
  localparam logic [1:0] ST_HOST = 2'd3;

  // special instructions (base op zero)
  localparam logic [7:0] INS_BRK = 8'h00;
  localparam logic [7:0] INS_JCI = 8'h20;
  localparam logic [7:0] INS_JMI = 8'h40;
  localparam logic [7:0] INS_JSI = 8'h60;

  // base operations
  localparam logic [4:0] OP_SPC = 5'h00;
  localparam logic [4:0] OP_INC = 5'h01;
  localparam logic [4:0] OP_POP = 5'h02;
  localparam logic [4:0] OP_NIP = 5'h03;
  localparam logic [4:0] OP_SWP = 5'h04;
  localparam logic [4:0] OP_ROT = 5'h05;
  localparam logic [4:0] OP_DUP = 5'h06;
  localparam logic [4:0] OP_OVR = 5'h07;
  localparam logic [4:0] OP_EQU = 5'h08;
  localparam logic [4:0] OP_NEQ = 5'h09;
  localparam logic [4:0] OP_GTH = 5'h0a;
  localparam logic [4:0] OP_LTH = 5'h0b;
  localparam logic [4:0] OP_JMP = 5'h0c;
  localparam logic [4:0] OP_JCN = 5'h0d;
  localparam logic [4:0] OP_JSR = 5'h0e;
  localparam logic [4:0] OP_STH = 5'h0f;
  localparam logic [4:0] OP_LDZ = 5'h10;
  localparam logic [4:0] OP_STZ = 5'h11;
  localparam logic [4:0] OP_LDR = 5'h12;
  localparam logic [4:0] OP_STR = 5'h13;
  localparam logic [4:0] OP_LDA = 5'h14;
  localparam logic [4:0] OP_STA = 5'h15;
  localparam logic [4:0] OP_DEI = 5'h16;
  localparam logic [4:0] OP_DEO = 5'h17;
  localparam logic [4:0] OP_ADD = 5'h18;
  localparam logic [4:0] OP_SUB = 5'h19;
  localparam logic [4:0] OP_MUL = 5'h1a;
  localparam logic [4:0] OP_DIV = 5'h1b;
  localparam logic [4:0] OP_AND = 5'h1c;
  localparam logic [4:0] OP_ORA = 5'h1d;
  localparam logic [4:0] OP_EOR = 5'h1e;
  localparam logic [4:0] OP_SFT = 5'h1f;

  localparam int STACK_DEPTH = 256;
  localparam int DEV_DEPTH   = 256;
  localparam logic [4:0] SLOT_END = 5'd6;   // three values of two bytes
  localparam logic [4:0] DIV_LAST = 5'd15;

  typedef enum logic [3:0] {
    S_IDLE, S_HOST, S_HRD, S_FETCH, S_DECODE, S_POP_RD, S_POP_CAP,
    S_DIV_INIT, S_DIV_RUN, S_LD_RD, S_LD_CAP, S_ST, S_EXEC, S_PUSH, S_DONE
  } state_t;

  // per-instruction sequencing plan; byte masks are indexed by slot*2+half
  typedef struct packed {
    logic [7:0] pop_mask;
    logic [7:0] push_mask;
    logic       push_sel;
    logic       use_div;
    logic [1:0] ld_n;
    logic       ld_dev;
    logic [1:0] st_n;
    logic       st_dev;
    logic       is_brk;
  } plan_t;

  typedef struct packed {
    logic       cap_in;
    logic       host_mwr;
    logic       host_mrd;
    logic       host_dwr;
    logic       start;
    logic       rd_cap;
    logic       fetch;
    logic       decode;
    logic       pop_rd;
    logic       pop_cap;
    logic       div_init;
    logic       div_step;
    logic       ld_rd;
    logic       ld_cap;
    logic       st_wr;
    logic       exec;
    logic       push;
    logic       out_load;
    logic [1:0] out_status;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       running;
    logic [7:0] ins;
  } stat_t;

  function automatic logic [15:0] smc_rel(logic [15:0] pc, logic [7:0] off);
    return pc + {{8{off[7]}}, off};
  endfunction

  function automatic plan_t smc_plan(logic [7:0] ins);
    plan_t      p;
    logic [4:0] op;
    logic       d;
    logic [1:0] pn;
    logic [1:0] un;
    logic [2:0] pw;
    logic [2:0] uw;
    op = ins[4:0];
    d  = ins[5];
    p  = '0;
    pn = 2'd0;
    un = 2'd0;
    pw = 3'b000;
    uw = {3{d}};
    p.push_sel = ins[6];
    if (op == OP_SPC) begin
      if (ins == INS_BRK) begin
        p.is_brk = 1'b1;
      end else if (ins == INS_JCI) begin
        pn = 2'd1;
        p.ld_n = 2'd2;
      end else if (ins == INS_JMI) begin
        p.ld_n = 2'd2;
      end else if (ins == INS_JSI) begin
        p.ld_n = 2'd2;
        un = 2'd1;
        uw = 3'b001;
        p.push_sel = 1'b1;
      end else begin
        // literal
        p.ld_n = {d, ~d};
        un = 2'd1;
      end
    end else begin
      unique case (op)
        OP_INC: begin pn = 2'd1; pw = {2'b00, d}; un = 2'd1; end
        OP_POP: begin pn = 2'd1; pw = {2'b00, d}; end
        OP_NIP: begin pn = 2'd2; pw = {1'b0, d, d}; un = 2'd1; end
        OP_SWP: begin pn = 2'd2; pw = {1'b0, d, d}; un = 2'd2; end
        OP_ROT: begin pn = 2'd3; pw = {d, d, d}; un = 2'd3; end
        OP_DUP: begin pn = 2'd1; pw = {2'b00, d}; un = 2'd2; end
        OP_OVR: begin pn = 2'd2; pw = {1'b0, d, d}; un = 2'd3; end
        OP_EQU, OP_NEQ, OP_GTH, OP_LTH: begin
          pn = 2'd2; pw = {1'b0, d, d}; un = 2'd1; uw = 3'b000;
        end
        OP_JMP: begin pn = 2'd1; pw = {2'b00, d}; end
        OP_JCN: begin pn = 2'd2; pw = {2'b00, d}; end
        OP_JSR: begin
          pn = 2'd1; pw = {2'b00, d}; un = 2'd1; uw = 3'b001; p.push_sel = ~ins[6];
        end
        OP_STH: begin pn = 2'd1; pw = {2'b00, d}; un = 2'd1; p.push_sel = ~ins[6]; end
        OP_LDZ, OP_LDR: begin pn = 2'd1; un = 2'd1; p.ld_n = {d, ~d}; end
        OP_LDA: begin pn = 2'd1; pw = 3'b001; un = 2'd1; p.ld_n = {d, ~d}; end
        OP_STZ, OP_STR: begin pn = 2'd2; pw = {1'b0, d, 1'b0}; p.st_n = {d, ~d}; end
        OP_STA: begin pn = 2'd2; pw = {1'b0, d, 1'b1}; p.st_n = {d, ~d}; end
        OP_DEI: begin pn = 2'd1; un = 2'd1; p.ld_n = {d, ~d}; p.ld_dev = 1'b1; end
        OP_DEO: begin
          pn = 2'd2; pw = {1'b0, d, 1'b0}; p.st_n = {d, ~d}; p.st_dev = 1'b1;
        end
        OP_SFT: begin pn = 2'd2; pw = {1'b0, d, 1'b0}; un = 2'd1; end
        OP_DIV: begin pn = 2'd2; pw = {1'b0, d, d}; un = 2'd1; p.use_div = 1'b1; end
        default: begin pn = 2'd2; pw = {1'b0, d, d}; un = 2'd1; end
      endcase
    end
    for (int s = 0; s < 3; s++) begin
      // pops take the low byte first, pushes the high byte first
      p.pop_mask[2*s]    = (2'(s) < pn);
      p.pop_mask[2*s+1]  = (2'(s) < pn) & pw[s];
      p.push_mask[2*s]   = (2'(s) < un) & uw[s];
      p.push_mask[2*s+1] = (2'(s) < un);
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/smc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: walks each host action or instruction through its phases.
// ----------------------------------------------------------------------------
module smc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  smc_pkg::stat_t stat,
  output smc_pkg::cmd_t  cmd
);
  import smc_pkg::*;

  state_t     state, state_next;
  logic [4:0] ctr, ctr_next;
  logic [1:0] code, code_next;
  logic       out_valid;
  plan_t      plan;
  logic [2:0] idx;

  assign plan     = smc_plan(stat.ins);
  assign idx      = ctr[2:0];
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ctr       <= '0;
      code      <= ST_HOST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ctr   <= ctr_next;
      code  <= code_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctr_next   = ctr;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_HOST;
      end
      S_HOST: begin
        code_next  = ST_HOST;
        state_next = S_DONE;
        if (stat.action == ACT_MEM_RD) begin
          state_next = S_HRD;
        end else if (stat.action == ACT_STEP) begin
          if (stat.running) begin
            code_next  = ST_EXEC;
            state_next = S_FETCH;
          end else begin
            code_next = ST_HALT;
          end
        end
      end
      S_HRD:    state_next = S_DONE;
      S_FETCH:  state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_POP_RD;
        ctr_next   = '0;
      end
      S_POP_RD: begin
        if (ctr == SLOT_END) begin
          state_next = plan.use_div ? S_DIV_INIT : S_LD_RD;
          ctr_next   = '0;
        end else if (plan.pop_mask[idx]) begin
          state_next = S_POP_CAP;
        end else begin
          ctr_next = ctr + 5'd1;
        end
      end
      S_POP_CAP: begin
        ctr_next   = ctr + 5'd1;
        state_next = S_POP_RD;
      end
      S_DIV_INIT: begin
        state_next = S_DIV_RUN;
        ctr_next   = '0;
      end
      S_DIV_RUN: begin
        ctr_next = ctr + 5'd1;
        if (ctr == DIV_LAST) begin
          state_next = S_LD_RD;
          ctr_next   = '0;
        end
      end
      S_LD_RD: begin
        if (ctr == {3'b000, plan.ld_n}) begin
          state_next = S_ST;
          ctr_next   = '0;
        end else begin
          state_next = S_LD_CAP;
        end
      end
      S_LD_CAP: begin
        ctr_next   = ctr + 5'd1;
        state_next = S_LD_RD;
      end
      S_ST: begin
        if (ctr == {3'b000, plan.st_n}) begin
          state_next = S_EXEC;
          ctr_next   = '0;
        end else begin
          ctr_next = ctr + 5'd1;
        end
      end
      S_EXEC: begin
        state_next = S_PUSH;
        ctr_next   = '0;
        if (plan.is_brk) code_next = ST_BRK;
      end
      S_PUSH: begin
        if (ctr == SLOT_END) begin
          state_next = S_DONE;
        end else begin
          ctr_next = ctr + 5'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.idx        = idx;
    cmd.out_status = code;
    unique case (state)
      S_IDLE: cmd.cap_in = s_tvalid;
      S_HOST: begin
        cmd.host_mwr = (stat.action == ACT_MEM_WR);
        cmd.host_mrd = (stat.action == ACT_MEM_RD);
        cmd.host_dwr = (stat.action == ACT_DEV_WR);
        cmd.start    = (stat.action == ACT_START);
      end
      S_HRD:      cmd.rd_cap   = 1'b1;
      S_FETCH:    cmd.fetch    = 1'b1;
      S_DECODE:   cmd.decode   = 1'b1;
      S_POP_RD:   cmd.pop_rd   = (ctr != SLOT_END) && plan.pop_mask[idx];
      S_POP_CAP:  cmd.pop_cap  = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV_RUN:  cmd.div_step = 1'b1;
      S_LD_RD:    cmd.ld_rd    = (ctr != {3'b000, plan.ld_n});
      S_LD_CAP:   cmd.ld_cap   = 1'b1;
      S_ST:       cmd.st_wr    = (ctr != {3'b000, plan.st_n});
      S_EXEC:     cmd.exec     = 1'b1;
      S_PUSH:     cmd.push     = plan.push_mask[idx];
      S_DONE:     cmd.out_load = !out_valid || m_tready;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/smc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_datapath
// Memory, stacks, device page, operand registers, divider and result regs.
// ----------------------------------------------------------------------------
module smc_datapath #(
  parameter int MEMORY_DEPTH = 65536
) (
  input  logic           clk,
  input  logic           rst,
  input  smc_pkg::cmd_t  cmd,
  output smc_pkg::stat_t stat,
  input  logic [23:0]    s_tdata,
  input  logic [2:0]     s_tuser,
  output logic [55:0]    m_tdata,
  output logic [1:0]     m_tuser
);
  import smc_pkg::*;

  localparam int AW = $clog2(MEMORY_DEPTH);

  logic [7:0]  mem [MEMORY_DEPTH];
  logic [7:0]  wstk [STACK_DEPTH];
  logic [7:0]  rstk [STACK_DEPTH];
  logic [7:0]  dev [DEV_DEPTH];
  logic [DEV_DEPTH-1:0] dev_vld;

  logic [2:0]  act;
  logic [15:0] haddr;
  logic [7:0]  hdata;
  logic [15:0] pc;
  logic        running;
  logic [7:0]  wptr, rptr, saved;
  logic [7:0]  ins;
  logic [15:0] opa, opb, opc;
  logic [7:0]  ld0, ld1;
  logic [15:0] div_q, div_r;
  logic [15:0] pv0, pv1, pv2;
  logic [7:0]  rd, port;
  logic [1:0]  cnt;
  logic [15:0] val;
  logic [7:0]  mem_q, wstk_q, rstk_q, dev_q, dev_rd;
  logic        dev_rv;

  plan_t       plan;
  logic [4:0]  op;
  logic        d, r, k;
  logic [15:0] base, base2, ls_addr;
  logic        mask8;
  logic [15:0] mra, mwa;
  logic [7:0]  mwd, st_byte, pop_byte, push_byte;
  logic        mwe, dwe;
  logic [7:0]  dwa, dwd;
  logic [15:0] pc_next, t16, ldv, jmp_tgt;
  logic [15:0] e0, e1, e2;
  logic [16:0] div_sh;

  assign plan = smc_plan(ins);
  assign op   = ins[4:0];
  assign d    = ins[5];
  assign r    = ins[6];
  assign k    = ins[7];

  assign stat.action  = act;
  assign stat.running = running;
  assign stat.ins     = ins;

  // load / store addressing
  always_comb begin
    mask8 = 1'b0;
    unique case (op)
      OP_LDZ, OP_STZ, OP_DEI, OP_DEO: begin
        base  = {8'h00, opa[7:0]};
        mask8 = 1'b1;
      end
      OP_LDR, OP_STR: base = smc_rel(pc, opa[7:0]);
      OP_LDA, OP_STA: base = opa;
      default:        base = pc;
    endcase
    base2   = mask8 ? {8'h00, base[7:0] + 8'd1} : base + 16'd1;
    ls_addr = cmd.idx[0] ? base2 : base;
    st_byte = (d && !cmd.idx[0]) ? opb[15:8] : opb[7:0];
  end

  // memory port selection
  always_comb begin
    mra = pc;
    if (cmd.host_mrd) mra = haddr;
    else if (cmd.ld_rd) mra = ls_addr;
    mwe = cmd.host_mwr || (cmd.st_wr && !plan.st_dev);
    mwa = cmd.host_mwr ? haddr : ls_addr;
    mwd = cmd.host_mwr ? hdata : st_byte;
    dwe = cmd.host_dwr || (cmd.st_wr && plan.st_dev);
    dwa = cmd.host_dwr ? haddr[7:0] : ls_addr[7:0];
    dwd = cmd.host_dwr ? hdata : st_byte;
  end

  // depth is a power of two, so the address wraps by truncation
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa[AW-1:0]] <= mwd;
    mem_q <= mem[mra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !plan.push_sel) wstk[wptr] <= push_byte;
    if (cmd.push && plan.push_sel)  rstk[rptr] <= push_byte;
    wstk_q <= wstk[wptr - 8'd1];
    rstk_q <= rstk[rptr - 8'd1];
  end

  always_ff @(posedge clk) begin
    if (dwe) dev[dwa] <= dwd;
    dev_rd <= dev[ls_addr[7:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_vld <= '0;
      dev_rv  <= 1'b0;
    end else begin
      if (dwe) dev_vld[dwa] <= 1'b1;
      dev_rv <= dev_vld[ls_addr[7:0]];
    end
  end

  assign dev_q    = dev_rv ? dev_rd : 8'h00;
  assign pop_byte = r ? rstk_q : wstk_q;

  // push byte: half zero is the high byte
  always_comb begin
    unique case (cmd.idx[2:1])
      2'd0:    push_byte = cmd.idx[0] ? pv0[7:0] : pv0[15:8];
      2'd1:    push_byte = cmd.idx[0] ? pv1[7:0] : pv1[15:8];
      default: push_byte = cmd.idx[0] ? pv2[7:0] : pv2[15:8];
    endcase
  end

  // execute
  always_comb begin
    t16     = {ld0, ld1};
    ldv     = d ? {ld0, ld1} : {8'h00, ld0};
    jmp_tgt = d ? opa : smc_rel(pc, opa[7:0]);
    pc_next = pc;
    e0      = 16'h0000;
    e1      = 16'h0000;
    e2      = 16'h0000;
    if (op == OP_SPC) begin
      if (ins == INS_JCI) begin
        pc_next = (opa[7:0] != 8'h00) ? pc + 16'd2 + t16 : pc + 16'd2;
      end else if (ins == INS_JMI) begin
        pc_next = pc + 16'd2 + t16;
      end else if (ins == INS_JSI) begin
        pc_next = pc + 16'd2 + t16;
        e0      = pc + 16'd2;
      end else if (ins != INS_BRK) begin
        pc_next = pc + (d ? 16'd2 : 16'd1);
        e0      = ldv;
      end
    end else begin
      unique case (op)
        OP_INC: e0 = opa + 16'd1;
        OP_NIP: e0 = opa;
        OP_SWP: begin e0 = opa; e1 = opb; end
        OP_ROT: begin e0 = opb; e1 = opa; e2 = opc; end
        OP_DUP: begin e0 = opa; e1 = opa; end
        OP_OVR: begin e0 = opb; e1 = opa; e2 = opb; end
        OP_EQU: e0 = {15'd0, opb == opa};
        OP_NEQ: e0 = {15'd0, opb != opa};
        OP_GTH: e0 = {15'd0, opb > opa};
        OP_LTH: e0 = {15'd0, opb < opa};
        OP_JMP: pc_next = jmp_tgt;
        OP_JCN: if (opb != 16'h0000) pc_next = jmp_tgt;
        OP_JSR: begin e0 = pc; pc_next = jmp_tgt; end
        OP_STH: e0 = opa;
        OP_LDZ, OP_LDR, OP_LDA, OP_DEI: e0 = ldv;
        OP_ADD: e0 = opb + opa;
        OP_SUB: e0 = opb - opa;
        OP_MUL: e0 = opb * opa;
        OP_DIV: e0 = (opa == 16'h0000) ? 16'h0000 : div_q;
        OP_AND: e0 = opb & opa;
        OP_ORA: e0 = opb | opa;
        OP_EOR: e0 = opb ^ opa;
        OP_SFT: e0 = (opb >> opa[3:0]) << opa[7:4];
        default: ;
      endcase
    end
  end

  // one restoring division step
  assign div_sh = {div_r, div_q[15]};

  // architectural control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      running <= 1'b0;
      wptr    <= '0;
      rptr    <= '0;
    end else begin
      if (cmd.start) begin
        pc      <= haddr;
        running <= 1'b1;
      end
      if (cmd.decode) pc <= pc + 16'd1;
      if (cmd.exec) begin
        pc <= pc_next;
        if (plan.is_brk) running <= 1'b0;
        if (k && op != OP_SPC) begin
          if (r) rptr <= saved;
          else   wptr <= saved;
        end
      end
      if (cmd.pop_rd) begin
        if (r) rptr <= rptr - 8'd1;
        else   wptr <= wptr - 8'd1;
      end
      if (cmd.push) begin
        if (plan.push_sel) rptr <= rptr + 8'd1;
        else               wptr <= wptr + 8'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      act   <= s_tuser;
      haddr <= s_tdata[15:0];
      hdata <= s_tdata[23:16];
      rd    <= 8'h00;
      cnt   <= 2'd0;
      port  <= 8'h00;
      val   <= 16'h0000;
    end
    if (cmd.rd_cap) rd <= mem_q;
    if (cmd.decode) begin
      ins   <= mem_q;
      saved <= mem_q[6] ? rptr : wptr;
      opa   <= 16'h0000;
      opb   <= 16'h0000;
      opc   <= 16'h0000;
    end
    if (cmd.pop_cap) begin
      unique case (cmd.idx[2:1])
        2'd0: if (cmd.idx[0]) opa[15:8] <= pop_byte; else opa[7:0] <= pop_byte;
        2'd1: if (cmd.idx[0]) opb[15:8] <= pop_byte; else opb[7:0] <= pop_byte;
        default: if (cmd.idx[0]) opc[15:8] <= pop_byte; else opc[7:0] <= pop_byte;
      endcase
    end
    if (cmd.div_init) begin
      div_q <= opb;
      div_r <= 16'h0000;
    end
    if (cmd.div_step) begin
      if (div_sh >= {1'b0, opa}) begin
        div_r <= 16'(div_sh - {1'b0, opa});
        div_q <= {div_q[14:0], 1'b1};
      end else begin
        div_r <= div_sh[15:0];
        div_q <= {div_q[14:0], 1'b0};
      end
    end
    if (cmd.ld_cap) begin
      if (cmd.idx[0]) ld1 <= plan.ld_dev ? dev_q : mem_q;
      else            ld0 <= plan.ld_dev ? dev_q : mem_q;
    end
    if (cmd.exec) begin
      pv0 <= e0;
      pv1 <= e1;
      pv2 <= e2;
      if (op == OP_DEO) begin
        cnt  <= d ? 2'd2 : 2'd1;
        port <= opa[7:0];
        val  <= opb;
      end
    end
    if (cmd.out_load) begin
      m_tuser <= cmd.out_status;
      m_tdata <= {6'd0, val, port, cnt, rd, pc};
    end
  end

endmodule

// ===== hw/rtl/stack_machine_cpu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_cpu_core
// Eight-bit stack machine with host load, read, device write, start and step.
// ----------------------------------------------------------------------------
//  port group  dir  width  content
//  s_*         in   24+3   host action: tdata addr, data; tuser action
//  m_*         out  56+2   result: tdata next_pc, read_data, dev_write_count,
//                          dev_port, dev_value; tuser status
//
// Host actions pass through the host state, a read capture for memory reads,
// and the done state; a step while halted does the same. A step runs fetch
// and decode, a pass over six operand byte slots (with a registered stack read
// and capture per popped byte), the radix-2 divider for DIV, a read and a
// capture per loaded byte, a write per stored byte, execute and a push pass.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is accepted. Reset clears pointers, pc,
// running and the device page valid bits; memories hold no reset value.
// ----------------------------------------------------------------------------
module stack_machine_cpu_core #(
  parameter int MEMORY_DEPTH = 65536   // power of two, 256 to 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // next_pc[15:0], read_data[23:16],
                                 // dev_write_count[25:24], dev_port[33:26],
                                 // dev_value[49:34], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);
  import smc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smc_datapath #(
    .MEMORY_DEPTH (MEMORY_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second item while busy");

  // device writes are only reported by executed instructions
  a_dev_only_exec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_EXEC) |-> (m_tdata[25:24] == 2'd0))
    else $error("device write reported outside instruction");

  // read data only for host accesses
  a_rd_only_host: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_HOST) |-> (m_tdata[23:16] == 8'h00))
    else $error("read data outside host access");

endmodule

// ===== bench/stack_machine_cpu_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_cpu_core_tb
// Self-checking bench for the stack machine core. Host items are generated
// up front while an in-bench instruction-set model tracks the machine state;
// that model predicts every result and writes any memory byte a step would
// read before it was loaded. Driver and monitor idle at random; the monitor
// compares each result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module stack_machine_cpu_core_tb;
  import smc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] next_pc;
    logic [7:0]  read_data;
    logic [1:0]  wr_cnt;
    logic [7:0]  port;
    logic [15:0] value;
  } result_t;

  typedef struct {
    logic [2:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          drain;
  } host_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  stack_machine_cpu_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- machine model ----------------
  logic [7:0]  mem_img [0:65535];
  bit          mem_ok [0:65535];
  logic [7:0]  wstk [0:255];
  logic [7:0]  rstk [0:255];
  logic [7:0]  dev_page [0:255];
  logic [7:0]  wptr, rptr;
  logic [15:0] cpu_pc;
  bit          cpu_run;
  bit          probing;
  logic [15:0] miss_q[$];

  logic [7:0]  sv_w [0:255];
  logic [7:0]  sv_r [0:255];
  logic [7:0]  sv_dev [0:255];

  function automatic logic [7:0] mem_fetch(logic [15:0] a);
    if (probing && !mem_ok[a]) miss_q.push_back(a);
    return mem_img[a];
  endfunction

  function automatic void mem_store(logic [15:0] a, logic [7:0] v);
    if (!probing) begin
      mem_img[a] = v;
      mem_ok[a] = 1'b1;
    end
  endfunction

  function automatic logic [7:0] stk_pop(bit s);
    if (s) begin
      rptr = rptr - 8'd1;
      return rstk[rptr];
    end
    wptr = wptr - 8'd1;
    return wstk[wptr];
  endfunction

  function automatic void stk_push(bit s, logic [7:0] v);
    if (s) begin
      rstk[rptr] = v;
      rptr = rptr + 8'd1;
    end else begin
      wstk[wptr] = v;
      wptr = wptr + 8'd1;
    end
  endfunction

  function automatic logic [15:0] stk_popv(bit s, bit d);
    logic [15:0] v;
    v = {8'h00, stk_pop(s)};
    if (d) v[15:8] = stk_pop(s);
    return v;
  endfunction

  function automatic void stk_pushv(bit s, bit d, logic [15:0] v);
    if (d) stk_push(s, v[15:8]);
    stk_push(s, v[7:0]);
  endfunction

  function automatic logic [15:0] fetch16(inout logic [15:0] q);
    logic [7:0] hi, lo;
    hi = mem_fetch(q);
    q = q + 16'd1;
    lo = mem_fetch(q);
    q = q + 16'd1;
    return {hi, lo};
  endfunction

  function automatic logic [15:0] rel16(logic [15:0] p, logic [15:0] a);
    return p + {{8{a[7]}}, a[7:0]};
  endfunction

  function automatic void cpu_exec(output logic [1:0] st, output logic [1:0] cnt,
                                   output logic [7:0] port, output logic [15:0] val);
    logic [15:0] p, a, b, c, t;
    logic [31:0] w;
    logic [7:0]  ins, saved, zp;
    logic [4:0]  op;
    bit          d, r, k;
    st = ST_EXEC; cnt = '0; port = '0; val = '0;
    a = '0; b = '0; c = '0;
    p = cpu_pc;
    ins = mem_fetch(p);
    p = p + 16'd1;
    op = ins[4:0]; d = ins[5]; r = ins[6]; k = ins[7];
    if (op == OP_SPC) begin
      case (ins)
        INS_BRK: begin
          cpu_pc = p;
          cpu_run = 1'b0;
          st = ST_BRK;
          return;
        end
        INS_JCI: begin
          if (stk_pop(1'b0) != 8'd0) begin
            t = fetch16(p);
            p = p + t;
          end else p = p + 16'd2;
        end
        INS_JMI: begin t = fetch16(p); p = p + t; end
        INS_JSI: begin t = fetch16(p); stk_pushv(1'b1, 1'b1, p); p = p + t; end
        default: begin
          // literals
          if (d) begin stk_push(r, mem_fetch(p)); p = p + 16'd1; end
          stk_push(r, mem_fetch(p));
          p = p + 16'd1;
        end
      endcase
      cpu_pc = p;
      return;
    end

    saved = r ? rptr : wptr;
    case (op)
      OP_POP: a = stk_popv(r, d);
      OP_NIP: begin a = stk_popv(r, d); b = stk_popv(r, d); end
      OP_ROT: begin a = stk_popv(r, d); b = stk_popv(r, d); c = stk_popv(r, d); end
      OP_INC, OP_DUP, OP_JMP, OP_JSR, OP_STH: a = stk_popv(r, d);
      OP_JCN: begin a = stk_popv(r, d); b = {8'h00, stk_pop(r)}; end
      OP_LDZ, OP_LDR, OP_DEI: a = {8'h00, stk_pop(r)};
      OP_STZ, OP_STR, OP_DEO, OP_SFT: begin a = {8'h00, stk_pop(r)}; b = stk_popv(r, d); end
      OP_LDA: a = stk_popv(r, 1'b1);
      OP_STA: begin a = stk_popv(r, 1'b1); b = stk_popv(r, d); end
      default: begin a = stk_popv(r, d); b = stk_popv(r, d); end
    endcase
    // keep mode restores the source pointer before the pushes
    if (k) begin
      if (r) rptr = saved;
      else wptr = saved;
    end

    zp = a[7:0] + 8'd1;
    case (op)
      OP_INC: stk_pushv(r, d, a + 16'd1);
      OP_NIP: stk_pushv(r, d, a);
      OP_SWP: begin stk_pushv(r, d, a); stk_pushv(r, d, b); end
      OP_ROT: begin stk_pushv(r, d, b); stk_pushv(r, d, a); stk_pushv(r, d, c); end
      OP_DUP: begin stk_pushv(r, d, a); stk_pushv(r, d, a); end
      OP_OVR: begin stk_pushv(r, d, b); stk_pushv(r, d, a); stk_pushv(r, d, b); end
      OP_EQU: stk_push(r, {7'd0, b == a});
      OP_NEQ: stk_push(r, {7'd0, b != a});
      OP_GTH: stk_push(r, {7'd0, b > a});
      OP_LTH: stk_push(r, {7'd0, b < a});
      OP_JMP: p = d ? a : rel16(p, a);
      OP_JCN: if (b != 16'd0) p = d ? a : rel16(p, a);
      OP_JSR: begin stk_pushv(!r, 1'b1, p); p = d ? a : rel16(p, a); end
      OP_STH: stk_pushv(!r, d, a);
      OP_LDZ: begin
        stk_push(r, mem_fetch({8'h00, a[7:0]}));
        if (d) stk_push(r, mem_fetch({8'h00, zp}));
      end
      OP_STZ: begin
        if (d) begin
          mem_store({8'h00, a[7:0]}, b[15:8]);
          mem_store({8'h00, zp}, b[7:0]);
        end else mem_store({8'h00, a[7:0]}, b[7:0]);
      end
      OP_LDR, OP_LDA: begin
        t = (op == OP_LDR) ? rel16(p, a) : a;
        stk_push(r, mem_fetch(t));
        if (d) stk_push(r, mem_fetch(t + 16'd1));
      end
      OP_STR, OP_STA: begin
        t = (op == OP_STR) ? rel16(p, a) : a;
        if (d) begin
          mem_store(t, b[15:8]);
          mem_store(t + 16'd1, b[7:0]);
        end else mem_store(t, b[7:0]);
      end
      OP_DEI: begin
        stk_push(r, dev_page[a[7:0]]);
        if (d) stk_push(r, dev_page[zp]);
      end
      OP_DEO: begin
        if (d) begin
          dev_page[a[7:0]] = b[15:8];
          dev_page[zp] = b[7:0];
          cnt = 2'd2;
        end else begin
          dev_page[a[7:0]] = b[7:0];
          cnt = 2'd1;
        end
        port = a[7:0];
        val = b;
      end
      OP_ADD: stk_pushv(r, d, b + a);
      OP_SUB: stk_pushv(r, d, b - a);
      OP_MUL: stk_pushv(r, d, b * a);
      OP_DIV: stk_pushv(r, d, (a != 16'd0) ? b / a : 16'd0);
      OP_AND: stk_pushv(r, d, b & a);
      OP_ORA: stk_pushv(r, d, b | a);
      OP_EOR: stk_pushv(r, d, b ^ a);
      OP_SFT: begin
        w = {16'h0000, b} >> a[3:0];
        w = w << a[7:4];
        stk_pushv(r, d, w[15:0]);
      end
      default: ;
    endcase
    cpu_pc = p;
  endfunction

  function automatic result_t host_predict(logic [2:0] act, logic [15:0] addr,
                                           logic [7:0] data);
    result_t     e;
    logic [1:0]  st, cnt;
    logic [7:0]  port;
    logic [15:0] val;
    e = '0;
    e.status = ST_HOST;
    case (act)
      ACT_MEM_WR: mem_store(addr, data);
      ACT_MEM_RD: e.read_data = mem_img[addr];
      ACT_DEV_WR: dev_page[addr[7:0]] = data;
      ACT_START: begin cpu_pc = addr; cpu_run = 1'b1; end
      ACT_STEP: begin
        if (!cpu_run) e.status = ST_HALT;
        else begin
          cpu_exec(st, cnt, port, val);
          e.status = st; e.wr_cnt = cnt; e.port = port; e.value = val;
        end
      end
      default: ;
    endcase
    e.next_pc = cpu_pc;
    return e;
  endfunction

  // dry run of one step: collects memory bytes it would read unwritten
  function automatic void probe_step();
    logic [1:0]  st, cnt;
    logic [7:0]  port, wp_s, rp_s;
    logic [15:0] val, pc_s;
    bit          run_s;
    sv_w = wstk; sv_r = rstk; sv_dev = dev_page;
    wp_s = wptr; rp_s = rptr; pc_s = cpu_pc; run_s = cpu_run;
    probing = 1'b1;
    cpu_exec(st, cnt, port, val);
    probing = 1'b0;
    wstk = sv_w; rstk = sv_r; dev_page = sv_dev;
    wptr = wp_s; rptr = rp_s; cpu_pc = pc_s; cpu_run = run_s;
  endfunction

  // ---------------- stimulus ----------------
  host_item_t host_q[$];
  result_t    planned_results[$];
  result_t    pending_results[$];
  int         n_queued = 0;

  task automatic queue_item(logic [2:0] act, logic [15:0] addr, logic [7:0] data);
    host_item_t it;
    it.action = act; it.addr = addr; it.data = data; it.drain = 1'b0;
    planned_results.push_back(host_predict(act, addr, data));
    host_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_drain();
    host_item_t it;
    it.action = ACT_MEM_RD; it.addr = '0; it.data = '0; it.drain = 1'b1;
    host_q.push_back(it);
  endtask

  task automatic queue_step();
    logic [15:0] fill [$];
    if (cpu_run) begin
      for (int i = 0; i < 4; i++) begin
        miss_q.delete();
        probe_step();
        if (miss_q.size() == 0) break;
        fill = miss_q;
        foreach (fill[j]) queue_item(ACT_MEM_WR, fill[j], 8'($urandom_range(0, 255)));
      end
    end
    queue_item(ACT_STEP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_ins(logic [7:0] ins);
    queue_item(ACT_MEM_WR, cpu_pc, ins);
    queue_step();
  endtask

  task automatic run_lit(logic [7:0] v);
    queue_item(ACT_MEM_WR, cpu_pc, 8'h80);
    queue_item(ACT_MEM_WR, cpu_pc + 16'd1, v);
    queue_step();
  endtask

  task automatic queue_random_item();
    int          pick;
    logic [15:0] a;
    logic [7:0]  ins;
    pick = $urandom_range(0, 99);
    a = 16'($urandom_range(0, 65535));
    if (pick < 75) begin
      if (!cpu_run) begin
        if ($urandom_range(0, 3) != 0) queue_item(ACT_START, a, 8'($urandom_range(0, 255)));
        else queue_step();
      end else if ($urandom_range(0, 6) != 0) begin
        ins = 8'($urandom_range(0, 255));
        if (ins == INS_BRK && $urandom_range(0, 3) != 0) ins = 8'h80;
        run_ins(ins);
      end else queue_step();
    end else if (pick < 83) begin
      queue_item(ACT_MEM_WR, a, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      if (!mem_ok[a]) queue_item(ACT_MEM_WR, a, 8'($urandom_range(0, 255)));
      queue_item(ACT_MEM_RD, a, 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      queue_item(ACT_DEV_WR, a, 8'($urandom_range(0, 255)));
    end else if (pick < 98) begin
      queue_item(3'($urandom_range(5, 7)), a, 8'($urandom_range(0, 255)));
    end else begin
      queue_item(ACT_START, a, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_stimulus();
    logic [7:0] prog [9];
    bit         drained;
    prog = '{8'ha0, 8'h12, 8'h34, 8'he0, 8'h56, 8'h78, 8'h40, 8'hff, 8'hf7};
    drained = 1'b0;
    for (int i = 0; i < 256; i++) dev_page[i] = 8'h00;
    wptr = '0; rptr = '0; cpu_pc = '0; cpu_run = 1'b0; probing = 1'b0;

    // halted machine, unused actions, edge addresses
    queue_step();
    queue_item(3'd5, 16'h0000, 8'h00);
    queue_item(3'd7, 16'hffff, 8'hff);
    queue_item(ACT_DEV_WR, 16'hffff, 8'hff);
    queue_item(ACT_DEV_WR, 16'h0000, 8'h00);
    queue_item(ACT_MEM_WR, 16'hffff, 8'hff);
    queue_item(ACT_MEM_RD, 16'hffff, 8'h00);

    // fill both stacks: LIT2 / LIT2r / JMI back, 128 rounds wrap each pointer
    foreach (prog[i]) queue_item(ACT_MEM_WR, 16'h0100 + 16'(i), prog[i]);
    queue_item(ACT_START, 16'h0100, 8'h00);
    repeat (384) queue_step();

    // pc wrap, divide by zero, short DEO and DEI across the port wrap, break
    queue_item(ACT_START, 16'hffff, 8'h00);
    run_lit(8'h05);
    run_lit(8'h00);
    run_ins({3'b000, OP_DIV});
    run_lit(8'hab);
    run_lit(8'hcd);
    run_lit(8'hff);
    run_ins({3'b001, OP_DEO});
    run_lit(8'hff);
    run_ins({3'b001, OP_DEI});
    run_ins(INS_BRK);
    queue_step();
    queue_drain();

    while (n_queued < 700) begin
      queue_random_item();
      if (n_queued >= 580 && !drained) begin
        queue_drain();
        drained = 1'b1;
      end
    end
  endtask

  // ---------------- driver ----------------
  host_item_t cur_item;
  result_t    cur_exp;
  int         tx_gap = 0;
  bit         tx_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pending_results.push_back(cur_exp);
      if (!s_tvalid || s_tready) begin
        if (host_q.size() > 0 && host_q[0].drain) begin
          // pause until every outstanding result is back
          if (pending_results.size() == 0) void'(host_q.pop_front());
          s_tvalid <= 1'b0;
        end else if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (host_q.size() > 0) begin
          cur_item = host_q.pop_front();
          cur_exp = planned_results.pop_front();
          s_tdata <= {cur_item.data, cur_item.addr};
          s_tuser <= cur_item.action;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int      n_errors = 0;
  int      n_results = 0;
  int      rx_wait = 0;
  int      rx_hold = 0;
  bit      rx_burst = 1'b0;
  bit      hold_done = 1'b0;
  result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.next_pc = m_tdata[15:0];
        got.read_data = m_tdata[23:16];
        got.wr_cnt = m_tdata[25:24];
        got.port = m_tdata[33:26];
        got.value = m_tdata[49:34];
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d mismatch: expected %p got %p", n_results, want, got);
          end
        end
        n_results++;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
        if (n_results == 450 && !hold_done) begin
          rx_hold = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (host_q.size() > 0 || s_tvalid || pending_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
